// File: hw/rtl/ffpd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ffpd_pkg;

	localparam int unsigned DATA_W = 8;
	localparam int unsigned KEY_W = 64;
	localparam int unsigned KLEN_W = 4;
	localparam logic [KLEN_W-1:0] MAX_KEY_BYTES = 4'd8;

	localparam int unsigned FIFO_DEPTH = 4;
	localparam int unsigned FIFO_AW = $clog2(FIFO_DEPTH);

	localparam logic REG_KEY_TEXT = 1'b0;
	localparam logic REG_KEY_LENGTH = 1'b1;

	localparam logic [DATA_W-1:0] CH_PLUS = 8'h2B;
	localparam logic [DATA_W-1:0] CH_PCT = 8'h25;
	localparam logic [DATA_W-1:0] CH_AMP = 8'h26;
	localparam logic [DATA_W-1:0] CH_EQ = 8'h3D;
	localparam logic [DATA_W-1:0] CH_SPACE = 8'h20;

	// results caused by one accepted byte, up to three
	typedef struct packed {
		logic [1:0] cnt;
		logic [2:0][DATA_W-1:0] val;
		logic data_ok;
		logic close;
		logic found;
	} bundle_t;

	function automatic logic is_hex(input logic [DATA_W-1:0] c);
		return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
			(c >= 8'h41 && c <= 8'h46);
	endfunction

	function automatic logic [3:0] hex_nib(input logic [DATA_W-1:0] c);
		logic [DATA_W-1:0] t;
		t = 8'h00;
		if (c >= 8'h30 && c <= 8'h39) begin
			t = c - 8'h30;
		end else if (c >= 8'h61 && c <= 8'h66) begin
			t = c - 8'h57;
		end else if (c >= 8'h41 && c <= 8'h46) begin
			t = c - 8'h37;
		end
		return t[3:0];
	endfunction

endpackage
`default_nettype wire

// File: hw/rtl/form_field_percent_decoder_top.sv
// form field percent decoder
// input channel: data_byte and last_byte, one body byte per transfer (push, full).
// result channel: value_byte, byte_valid, value_last, found (empty, pop); the oldest
// result sits on the ports while empty is low.
// config: wr_en, wr_index, wr_data; index 0 key_text, index 1 key_length. write only
// while no results are outstanding.
// each byte is classified in the cycle it is taken and yields zero to three results;
// those go as one bundle into a four-entry queue. a byte with no result leaves nothing
// unless it is the closing byte, which leaves one result with byte_valid low. the back
// end drains one result per cycle, while the receiver pops, into an output register.
// throughput: one byte per cycle while bytes give at most one result each and results
// are popped; results of a byte that gives several go out one per cycle at the port.
// full rises when the queue holds four bundles; a stalled receiver backs up
// through the queue to full without loss.
// reset clears key registers, parse state, queue and output valid flag; empty is high.
`timescale 1ns / 1ps
`default_nettype none
module form_field_percent_decoder_top (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        wr_en,
	input  wire logic                        wr_index,
	input  wire logic [ffpd_pkg::KEY_W-1:0]  wr_data,
	input  wire logic                        push,
	output      logic                        full,
	input  wire logic [ffpd_pkg::DATA_W-1:0] data_byte,
	input  wire logic                        last_byte,
	output      logic                        empty,
	input  wire logic                        pop,
	output      logic [ffpd_pkg::DATA_W-1:0] value_byte,
	output      logic                        byte_valid,
	output      logic                        value_last,
	output      logic                        found
);
	import ffpd_pkg::*;

	logic    acc;
	logic    fifo_wr, fifo_rd, fifo_empty;
	bundle_t fifo_wdata, fifo_head;

	assign acc = push & ~full;

	ffpd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr_en      (wr_en),
		.wr_index   (wr_index),
		.wr_data    (wr_data),
		.data_byte  (data_byte),
		.last_byte  (last_byte),
		.acc        (acc),
		.fifo_wr    (fifo_wr),
		.fifo_wdata (fifo_wdata)
	);

	ffpd_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (fifo_wr),
		.wdata  (fifo_wdata),
		.rd     (fifo_rd),
		.head   (fifo_head),
		.full   (full),
		.empty  (fifo_empty)
	);

	ffpd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (fifo_head),
		.head_empty (fifo_empty),
		.rd         (fifo_rd),
		.pop        (pop),
		.empty      (empty),
		.value_byte (value_byte),
		.byte_valid (byte_valid),
		.value_last (value_last),
		.found      (found)
	);

endmodule
`default_nettype wire

// File: hw/rtl/ffpd_front.sv
`timescale 1ns / 1ps
`default_nettype none
module ffpd_front (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             wr_en,
	input  wire logic                             wr_index,
	input  wire logic [ffpd_pkg::KEY_W-1:0]       wr_data,
	input  wire logic [ffpd_pkg::DATA_W-1:0]      data_byte,
	input  wire logic                             last_byte,
	input  wire logic                             acc,
	output      logic                             fifo_wr,
	output      ffpd_pkg::bundle_t                fifo_wdata
);
	import ffpd_pkg::*;

	typedef enum logic [1:0] {PH_MATCH, PH_SKIP, PH_VALUE, PH_DONE} phase_t;

	logic [KEY_W-1:0]  key_text_q;
	logic [KLEN_W-1:0] key_len_q;
	phase_t            phase_q, phase_d;
	logic [KLEN_W-1:0] mc_q, mc_d;
	logic [1:0]        pc_q, pc_d;
	logic [DATA_W-1:0] p1_q, p1_d;
	logic              found_q, found_d;
	logic [KLEN_W-1:0] klen;
	bundle_t           bun;
	logic              has_data;

	assign klen = (key_len_q > MAX_KEY_BYTES) ? MAX_KEY_BYTES : key_len_q;

	always_comb begin
		logic [1:0] n;
		logic do_plain;
		n = 2'd0;
		do_plain = 1'b0;
		phase_d = phase_q;
		mc_d = mc_q;
		pc_d = pc_q;
		p1_d = p1_q;
		found_d = found_q;
		bun = '0;
		case (phase_q)
			PH_MATCH: begin
				if (data_byte == CH_AMP) begin
					mc_d = '0;
				end else if (mc_q >= klen) begin
					if (data_byte == CH_EQ) begin
						phase_d = PH_VALUE;
						found_d = 1'b1;
						pc_d = 2'd0;
					end else begin
						phase_d = PH_SKIP;
					end
				end else if (data_byte == key_text_q[{mc_q[2:0], 3'b000} +: DATA_W]) begin
					mc_d = mc_q + 4'd1;
				end else begin
					phase_d = PH_SKIP;
				end
			end
			PH_SKIP: begin
				if (data_byte == CH_AMP) begin
					phase_d = PH_MATCH;
					mc_d = '0;
				end
			end
			PH_VALUE: begin
				if (data_byte == CH_AMP) begin
					if (pc_q >= 2'd1) begin
						bun.val[n] = CH_PCT;
						n = n + 2'd1;
					end
					if (pc_q >= 2'd2) begin
						bun.val[n] = p1_q;
						n = n + 2'd1;
					end
					pc_d = 2'd0;
					phase_d = PH_DONE;
				end else begin
					case (pc_q)
						2'd1: begin
							if (is_hex(data_byte)) begin
								p1_d = data_byte;
								pc_d = 2'd2;
							end else begin
								bun.val[n] = CH_PCT;
								n = n + 2'd1;
								pc_d = 2'd0;
								do_plain = 1'b1;
							end
						end
						2'd2: begin
							if (is_hex(data_byte)) begin
								bun.val[n] = {hex_nib(p1_q), hex_nib(data_byte)};
								n = n + 2'd1;
								pc_d = 2'd0;
							end else begin
								bun.val[n] = CH_PCT;
								n = n + 2'd1;
								bun.val[n] = p1_q;
								n = n + 2'd1;
								pc_d = 2'd0;
								do_plain = 1'b1;
							end
						end
						default: do_plain = 1'b1;
					endcase
					if (do_plain) begin
						if (data_byte == CH_PLUS) begin
							bun.val[n] = CH_SPACE;
							n = n + 2'd1;
						end else if (data_byte == CH_PCT) begin
							pc_d = 2'd1;
						end else begin
							bun.val[n] = data_byte;
							n = n + 2'd1;
						end
					end
				end
			end
			default: ;
		endcase
		// pair ends with the body: held bytes go out literally
		if (last_byte && phase_d == PH_VALUE) begin
			if (pc_d >= 2'd1) begin
				bun.val[n] = CH_PCT;
				n = n + 2'd1;
			end
			if (pc_d >= 2'd2) begin
				bun.val[n] = p1_d;
				n = n + 2'd1;
			end
		end
		has_data = (n != 2'd0);
		bun.data_ok = has_data;
		bun.close = last_byte;
		bun.found = last_byte & found_d;
		bun.cnt = has_data ? n : 2'd1;
	end

	assign fifo_wr = acc & (has_data | last_byte);
	assign fifo_wdata = bun;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_text_q <= '0;
			key_len_q <= '0;
			phase_q <= PH_MATCH;
			mc_q <= '0;
			pc_q <= 2'd0;
			p1_q <= '0;
			found_q <= 1'b0;
		end else begin
			if (wr_en) begin
				case (wr_index)
					REG_KEY_TEXT: key_text_q <= wr_data;
					REG_KEY_LENGTH: key_len_q <= wr_data[KLEN_W-1:0];
					default: ;
				endcase
			end
			if (acc) begin
				if (last_byte) begin
					phase_q <= PH_MATCH;
					mc_q <= '0;
					pc_q <= 2'd0;
					p1_q <= '0;
					found_q <= 1'b0;
				end else begin
					phase_q <= phase_d;
					mc_q <= mc_d;
					pc_q <= pc_d;
					p1_q <= p1_d;
					found_q <= found_d;
				end
			end
		end
	end

	a_body_reset: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && last_byte) |=> (phase_q == PH_MATCH && pc_q == 2'd0 && !found_q))
		else $error("body state not cleared after closing byte");

endmodule
`default_nettype wire

// File: hw/rtl/ffpd_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
module ffpd_fifo (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              wr,
	input  wire ffpd_pkg::bundle_t wdata,
	input  wire logic              rd,
	output      ffpd_pkg::bundle_t head,
	output      logic              full,
	output      logic              empty
);
	import ffpd_pkg::*;

	bundle_t            mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wptr_q, rptr_q;
	logic [FIFO_AW:0]   cnt_q;

	assign full = (cnt_q == (FIFO_AW+1)'(FIFO_DEPTH));
	assign empty = (cnt_q == '0);
	assign head = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) begin
				wptr_q <= wptr_q + FIFO_AW'(1);
			end
			if (rd) begin
				rptr_q <= rptr_q + FIFO_AW'(1);
			end
			case ({wr, rd})
				2'b10: cnt_q <= cnt_q + (FIFO_AW+1)'(1);
				2'b01: cnt_q <= cnt_q - (FIFO_AW+1)'(1);
				default: ;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n) wr |-> !full)
		else $error("transfer into full bundle queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n) rd |-> !empty)
		else $error("read from empty bundle queue");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (FIFO_AW+1)'(FIFO_DEPTH))
		else $error("bundle queue count out of range");

endmodule
`default_nettype wire

// File: hw/rtl/ffpd_back.sv
`timescale 1ns / 1ps
`default_nettype none
module ffpd_back (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire ffpd_pkg::bundle_t           head,
	input  wire logic                        head_empty,
	output      logic                        rd,
	input  wire logic                        pop,
	output      logic                        empty,
	output      logic [ffpd_pkg::DATA_W-1:0] value_byte,
	output      logic                        byte_valid,
	output      logic                        value_last,
	output      logic                        found
);
	import ffpd_pkg::*;

	logic [1:0]        idx_q;
	logic              oval_q;
	logic [DATA_W-1:0] obyte_q;
	logic              ovalid_q, olast_q, ofound_q;
	logic              load, tail;

	assign load = !head_empty && (!oval_q || pop);
	assign tail = ((idx_q + 2'd1) == head.cnt);
	assign rd = load && tail;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= 2'd0;
			oval_q <= 1'b0;
		end else begin
			if (load) begin
				oval_q <= 1'b1;
				idx_q <= tail ? 2'd0 : idx_q + 2'd1;
			end else if (pop) begin
				oval_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			obyte_q <= head.data_ok ? head.val[idx_q] : '0;
			ovalid_q <= head.data_ok;
			olast_q <= tail & head.close;
			ofound_q <= tail & head.found;
		end
	end

	assign empty = !oval_q;
	assign value_byte = obyte_q;
	assign byte_valid = ovalid_q;
	assign value_last = olast_q;
	assign found = ofound_q;

	a_head_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		!head_empty |-> head.cnt != 2'd0)
		else $error("empty bundle in queue");
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		!head_empty |-> idx_q < head.cnt)
		else $error("result index past bundle end");

endmodule
`default_nettype wire
